// ===== src/csr_command_framer_assert.svh =====
// Assertion macros shared by the framer RTL.
`ifndef CSR_COMMAND_FRAMER_ASSERT_SVH
`define CSR_COMMAND_FRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CMF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CMF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cmf_pkg.sv =====
// Shared constants, codes and control/status types of the command framer.
`timescale 1ns / 1ps

package cmf_pkg;

    // Byte count width; the count port itself is 16 bits.
    localparam int COUNT_WIDTH = 16;
    localparam int CNT_W       = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

    // Frame counter and its divider.
    localparam int FL_W      = 12;
    localparam int DIV_STEPS = FL_W;
    localparam int DIV_CNT_W = 4;

    localparam int CFG_IDX_W = 8;

    // Input item commands.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WORD_SIZE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_REGISTER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_PROGRAM = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_DRAM    = 8'd3;

    // Fixed bytes.
    localparam logic [7:0] NOP_BYTE    = 8'h00;
    localparam logic [7:0] READ_FILL   = 8'hdd;
    localparam logic [7:0] DRAM_PREFIX = 8'h0f;
    localparam logic [7:0] WRITE_BIT   = 8'h80;

    // Frame size codes.
    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_1    = 2'd1;
    localparam logic [1:0] SIZE_4    = 2'd2;
    localparam logic [1:0] SIZE_16   = 2'd3;

    // Targets.
    localparam logic [1:0] TGT_REG  = 2'd0;
    localparam logic [1:0] TGT_PROG = 2'd1;
    localparam logic [1:0] TGT_DRAM = 2'd2;
    localparam logic [1:0] TGT_NONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_PAY,
        ST_NOP,
        ST_PLAN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_PAY,
        SEL_NOP
    } emit_sel_t;

    // Controller to datapath.
    typedef struct packed {
        logic      start;
        logic      step;
        logic      emit;
        emit_sel_t sel;
        logic [2:0] hdr_idx;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       active;
        logic       hdr_first;
        logic [2:0] hdr_len;
        logic       nop_needed;
        logic       out_free;
        logic       plan_busy;
    } dp_status_t;

endpackage

// ===== src/cmf_div.sv =====
// Restoring divider, one quotient bit per cycle: frames = (bytes / 16) / word size.
`timescale 1ns / 1ps

module cmf_div
    import cmf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [FL_W-1:0] dividend,
    input  logic [3:0]      divisor,
    output logic            busy,
    output logic [FL_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [FL_W-1:0]      quo_reg;
    logic [3:0]           rem_reg;
    logic [3:0]           dvs_reg;

    logic [4:0] rem_sh;
    logic [4:0] rem_new;
    logic       ge;

    // One restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[FL_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_new = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Shift registers; quotient bits enter from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 4'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[FL_W-2:0], ge};
            rem_reg <= rem_new[3:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/cmf_datapath.sv =====
// Framer datapath: registers, access state, header bytes, planning and output register.
`timescale 1ns / 1ps

module cmf_datapath
    import cmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            ctrl,
    output dp_status_t           status,
    input  logic [1:0]           target,
    input  logic                 is_write,
    input  logic [31:0]          start_address,
    input  logic [15:0]          byte_count,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 end_of_transaction,
    output logic                 command_done,
    output logic                 last_of_run
);

    // Configuration
    logic [3:0] word_size_reg;
    logic [7:0] code_register_reg;
    logic [7:0] code_program_reg;
    logic [7:0] code_dram_reg;

    // Access state
    logic             active_reg;
    logic [1:0]       cur_target_reg;
    logic             write_flag_reg;
    logic [31:0]      word_address_reg;
    logic [CNT_W-1:0] bytes_left_reg;
    logic [FL_W-1:0]  frames_left_reg;
    logic [1:0]       size_code_reg;
    logic [7:0]       frame_byte_index_reg;
    logic             frames_pend_reg;
    logic [7:0]       data_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       eot_reg;
    logic       done_reg;
    logic       last_reg;

    logic [3:0]       eff_ws;
    logic [7:0]       chunk;
    logic [4:0]       words;
    logic [7:0]       fbi_inc;
    logic             frame_end;
    logic [CNT_W-1:0] chunk_ext;
    logic [CNT_W-1:0] bl_sub;
    logic [FL_W-1:0]  fl_dec;
    logic             nop_needed;
    logic [CNT_W-1:0] plan_bl;
    logic [15:0]      plan_bl16;
    logic [2:0]       plan_res;
    logic             pay_emit;
    logic             do_plan;
    logic             div_start;
    logic             div_busy;
    logic [FL_W-1:0]  div_q;
    logic [7:0]       cmd_byte;
    logic [7:0]       code;
    logic [7:0]       hdr_byte;
    logic [2:0]       hdr_len;
    logic             out_free;
    logic [7:0]       emit_byte;

    // Pick the frame size for the bytes that remain
    function automatic logic [2:0] plan_fn(input logic [CNT_W-1:0] bl, input logic [3:0] ws);
        logic [CNT_W-1:0] c16;
        logic [CNT_W-1:0] c4;
        logic [CNT_W-1:0] c1;
        c16 = CNT_W'({ws, 4'b0000});
        c4  = CNT_W'({ws, 2'b00});
        c1  = CNT_W'(ws);
        priority if (bl < c1)
            return {1'b0, SIZE_NONE};
        else if (bl >= c16)
            return {1'b1, SIZE_16};
        else if (bl >= c4)
            return {1'b1, SIZE_4};
        else
            return {1'b1, SIZE_1};
    endfunction

    // Word size clamped to 1..8
    always_comb
    begin
        priority if (word_size_reg == 4'd0)
            eff_ws = 4'd1;
        else if (word_size_reg > 4'd8)
            eff_ws = 4'd8;
        else
            eff_ws = word_size_reg;
    end

    // Current frame length in bytes and words
    always_comb
    begin
        unique case (size_code_reg)
            SIZE_16:
            begin
                chunk = {eff_ws, 4'b0000};
                words = 5'd16;
            end
            SIZE_4:
            begin
                chunk = {2'b00, eff_ws, 2'b00};
                words = 5'd4;
            end
            default:
            begin
                chunk = {4'b0000, eff_ws};
                words = 5'd1;
            end
        endcase
    end

    // Frame end and the state after it
    always_comb
    begin
        fbi_inc    = frame_byte_index_reg + 8'd1;
        frame_end  = (fbi_inc >= chunk);
        chunk_ext  = CNT_W'(chunk);
        bl_sub     = (bytes_left_reg >= chunk_ext) ? (bytes_left_reg - chunk_ext) : '0;
        fl_dec     = (frames_left_reg != '0) ? (frames_left_reg - 1'b1) : '0;
        nop_needed = frame_end && (frames_left_reg <= FL_W'(1));
    end

    // Planning, at a start item or after the last frame of a transaction
    always_comb
    begin
        pay_emit  = ctrl.emit && (ctrl.sel == SEL_PAY);
        plan_bl   = ctrl.start ? CNT_W'(byte_count) : bl_sub;
        plan_bl16 = 16'(plan_bl);
        plan_res  = plan_fn(plan_bl, eff_ws);
        do_plan   = ctrl.start || (pay_emit && nop_needed);
        div_start = do_plan && (plan_res[1:0] == SIZE_16);
    end

    cmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (plan_bl16[15:4]),
        .divisor  (eff_ws),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_size_reg     <= 4'd4;
            code_register_reg <= 8'd0;
            code_program_reg  <= 8'd0;
            code_dram_reg     <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WORD_SIZE:     word_size_reg     <= cfg_data[3:0];
                REG_CODE_REGISTER: code_register_reg <= cfg_data;
                REG_CODE_PROGRAM:  code_program_reg  <= cfg_data;
                REG_CODE_DRAM:     code_dram_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Access state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg           <= 1'b0;
            cur_target_reg       <= 2'd0;
            write_flag_reg       <= 1'b0;
            word_address_reg     <= 32'd0;
            bytes_left_reg       <= '0;
            frames_left_reg      <= '0;
            size_code_reg        <= SIZE_NONE;
            frame_byte_index_reg <= 8'd0;
            frames_pend_reg      <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cur_target_reg       <= target;
            write_flag_reg       <= is_write;
            word_address_reg     <= start_address;
            bytes_left_reg       <= plan_bl;
            frame_byte_index_reg <= 8'd0;
            active_reg           <= plan_res[2];
            size_code_reg        <= plan_res[1:0];
            frames_left_reg      <= FL_W'(plan_res[2]);
            frames_pend_reg      <= div_start;
        end
        else if (pay_emit)
        begin
            if (frame_end)
            begin
                frame_byte_index_reg <= 8'd0;
                word_address_reg     <= word_address_reg + 32'(words);
                bytes_left_reg       <= bl_sub;
                if (nop_needed)
                begin
                    active_reg      <= plan_res[2];
                    size_code_reg   <= plan_res[1:0];
                    frames_left_reg <= FL_W'(plan_res[2]);
                    frames_pend_reg <= div_start;
                end
                else
                begin
                    frames_left_reg <= fl_dec;
                end
            end
            else
            begin
                frame_byte_index_reg <= fbi_inc;
            end
        end
        else if (frames_pend_reg && !div_busy)
        begin
            frames_left_reg <= div_q;
            frames_pend_reg <= 1'b0;
        end
    end

    // Payload byte of the accepted step
    always_ff @(posedge clk)
    begin
        if (ctrl.step)
            data_reg <= data_byte;
    end

    // Command byte and header bytes
    always_comb
    begin
        unique case (cur_target_reg)
            TGT_REG:  code = code_register_reg;
            TGT_PROG: code = code_program_reg;
            default:  code = code_dram_reg;
        endcase
        cmd_byte = (write_flag_reg ? WRITE_BIT : 8'h00) | code | {1'b0, size_code_reg, 5'b00000};
    end

    always_comb
    begin
        unique case (cur_target_reg)
            TGT_REG:
            begin
                hdr_len = 3'd2;
                if (ctrl.hdr_idx == 3'd0)
                    hdr_byte = cmd_byte | {4'b0000, word_address_reg[11:8]};
                else
                    hdr_byte = word_address_reg[7:0];
            end
            TGT_PROG:
            begin
                hdr_len = 3'd3;
                unique case (ctrl.hdr_idx)
                    3'd0:    hdr_byte = cmd_byte | {4'b0000, word_address_reg[19:16]};
                    3'd1:    hdr_byte = word_address_reg[15:8];
                    default: hdr_byte = word_address_reg[7:0];
                endcase
            end
            TGT_DRAM:
            begin
                hdr_len = 3'd6;
                unique case (ctrl.hdr_idx)
                    3'd0:    hdr_byte = DRAM_PREFIX;
                    3'd1:    hdr_byte = cmd_byte;
                    3'd2:    hdr_byte = word_address_reg[31:24];
                    3'd3:    hdr_byte = word_address_reg[23:16];
                    3'd4:    hdr_byte = word_address_reg[15:8];
                    default: hdr_byte = word_address_reg[7:0];
                endcase
            end
            TGT_NONE:
            begin
                hdr_len  = 3'd0;
                hdr_byte = NOP_BYTE;
            end
            default:
            begin
                hdr_len  = 3'd0;
                hdr_byte = NOP_BYTE;
            end
        endcase
    end

    // Byte for the output register
    always_comb
    begin
        unique case (ctrl.sel)
            SEL_HDR: emit_byte = hdr_byte;
            SEL_PAY: emit_byte = write_flag_reg ? data_reg : READ_FILL;
            SEL_NOP: emit_byte = NOP_BYTE;
            default: emit_byte = NOP_BYTE;
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_byte_reg <= emit_byte;
            eot_reg      <= (ctrl.sel == SEL_NOP);
            done_reg     <= (ctrl.sel == SEL_NOP) && !active_reg;
            last_reg     <= (ctrl.sel == SEL_NOP) || ((ctrl.sel == SEL_PAY) && !nop_needed);
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_byte           = out_byte_reg;
    assign end_of_transaction = eot_reg;
    assign command_done       = done_reg;
    assign last_of_run        = last_reg;

    // Status to the controller
    always_comb
    begin
        status.active     = active_reg;
        status.hdr_first  = (frame_byte_index_reg == 8'd0);
        status.hdr_len    = hdr_len;
        status.nop_needed = nop_needed;
        status.out_free   = out_free;
        status.plan_busy  = frames_pend_reg;
    end

endmodule

// ===== src/cmf_ctrl.sv =====
// Framer controller: sequences header, payload and NOP bytes of one item.
`timescale 1ns / 1ps

module cmf_ctrl
    import cmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       command,
    input  dp_status_t status,
    output logic       in_stall,
    output ctrl_cmd_t  ctrl
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [2:0]  hdr_cnt_reg;
    logic [2:0]  hdr_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hdr_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_START)
                        state_next = ST_PLAN;
                    else if (status.active)
                    begin
                        hdr_cnt_next = 3'd0;
                        if (status.hdr_first && (status.hdr_len != 3'd0))
                            state_next = ST_HDR;
                        else
                            state_next = ST_PAY;
                    end
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    if (hdr_cnt_reg == (status.hdr_len - 3'd1))
                        state_next = ST_PAY;
                    else
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end
            end
            ST_PAY:
            begin
                if (status.out_free)
                    state_next = status.nop_needed ? ST_NOP : ST_IDLE;
            end
            ST_NOP:
            begin
                if (status.out_free)
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                if (!status.plan_busy)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        ctrl         = '0;
        ctrl.sel     = SEL_PAY;
        ctrl.hdr_idx = hdr_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.start = in_valid && (command == CMD_START);
                ctrl.step  = in_valid && (command == CMD_STEP);
            end
            ST_HDR:
            begin
                ctrl.emit = status.out_free;
                ctrl.sel  = SEL_HDR;
            end
            ST_PAY:
            begin
                ctrl.emit = status.out_free;
                ctrl.sel  = SEL_PAY;
            end
            ST_NOP:
            begin
                ctrl.emit = status.out_free;
                ctrl.sel  = SEL_NOP;
            end
            default:
                ;
        endcase
    end

endmodule

// ===== src/csr_command_framer.sv =====
// Top level of the command framer: controller, datapath and checks.
//
// Input channel (in_valid / in_stall): a start item (command 0) latches target,
// direction, word address and byte count; a step item (command 1) brings one
// payload byte slot. Results leave on the output channel
// (out_valid / out_stall) through a single output register.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, writes belong to idle periods.
// A step item that needs no header is accepted, then its payload byte is sent.
// The first step of a frame adds 2, 3 or 6 header bytes for register,
// program or DRAM targets. The step that ends a transaction adds the NOP byte;
// when 16-word frames are planned, in_stall stays high while the frame-count
// divider (one quotient bit per cycle) runs. A start item likewise waits for
// the divider when 16-word frames are planned.
// Reset clears the access, the output register and restores the registers
// (word size 4, target codes 0). A stalled receiver holds the output byte and
// the controller waits, so in_stall stays high until the item is sent.
`timescale 1ns / 1ps

module csr_command_framer
    import cmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [1:0]           target,
    input  logic                 is_write,
    input  logic [31:0]          start_address,
    input  logic [15:0]          byte_count,
    input  logic [7:0]           data_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 end_of_transaction,
    output logic                 command_done,
    output logic                 last_of_run,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

`include "csr_command_framer_assert.svh"

    ctrl_cmd_t  ctrl;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    cmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (dp_status),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    cmf_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .status             (dp_status),
        .target             (target),
        .is_write           (is_write),
        .start_address      (start_address),
        .byte_count         (byte_count),
        .data_byte          (data_byte),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .out_byte           (out_byte),
        .end_of_transaction (end_of_transaction),
        .command_done       (command_done),
        .last_of_run        (last_of_run)
    );

    // Checks
    `CMF_ASSERT_IMP(a_eot_is_last_nop, out_valid && end_of_transaction, (out_byte == NOP_BYTE) && last_of_run, "end of transaction not on a final NOP byte")
    `CMF_ASSERT_IMP(a_done_on_eot, out_valid && command_done, end_of_transaction, "command done outside a NOP byte")
    `CMF_ASSERT_NXT(a_step_holds_input, in_valid && !in_stall && (command == CMD_STEP) && dp_status.active, in_stall, "active step accepted without holding the input")
    `CMF_ASSERT_IMP(a_no_accept_while_planning, dp_status.plan_busy, in_stall, "input open while frame count is pending")

endmodule
